FILE: design/usbet_pkg.sv
// Shared types, codes and constants for the USB endpoint transfer tracker.
package usbet_pkg;

   localparam int USBET_NUM_SLOTS     = 16;
   localparam int USBET_HS_MAX_PACKET = 512;

   localparam int SLOT_W      = 4;
   localparam int LEN_W       = 16;
   localparam int ADDR_W      = 32;
   localparam int BYTES_W     = 10;
   localparam int LIM_W       = 11;
   localparam int MASK_W      = 16;
   localparam int MAX_SLOTS   = 1 << SLOT_W;

   localparam int FS_SMALL_PACKET = 16;
   localparam int FS_LARGE_PACKET = 64;
   localparam int FS_SMALL_SLOTS  = 4;

   typedef enum logic [1:0] {
      CMD_SUBMIT    = 2'd0,
      CMD_EVENT     = 2'd1,
      CMD_BUS_RESET = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SEND   = 2'd1,
      ACT_READ   = 2'd2,
      ACT_STATUS = 2'd3
   } action_type;

   typedef enum logic {
      KIND_HIGH_SPEED = 1'b0,
      KIND_FULL_SPEED = 1'b1
   } kind_type;

   typedef struct packed {
      logic              active;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  remaining;
      logic [LEN_W-1:0]  total;
   } tbl_rd_type;

   typedef struct packed {
      logic              en;
      logic              clear_all;
      logic              act_wr;
      logic              act_val;
      logic              data_wr;
      logic              total_wr;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  remaining;
      logic [LEN_W-1:0]  total;
      logic [MASK_W-1:0] pend_next;
   } tbl_wr_type;

   typedef struct packed {
      logic               ok;
      action_type         action;
      logic [BYTES_W-1:0] move_bytes;
      logic [ADDR_W-1:0]  move_address;
      logic               complete;
      logic [LEN_W-1:0]   complete_length;
      logic [MASK_W-1:0]  pending_mask;
   } rsp_type;

endpackage

FILE: design/usbet_slot_table.sv
// Per-slot transfer table and pending bits, one slot read and written per cycle.
module usbet_slot_table
   import usbet_pkg::*;
#(
   parameter int DEPTH = USBET_NUM_SLOTS,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  tbl_wr_type       wr,
   output tbl_rd_type       rd,
   output logic [MASK_W-1:0] pend
);

   logic [DEPTH-1:0]  active_ff;
   logic [DEPTH-1:0]  active_in;
   logic [ADDR_W-1:0] address_ff   [DEPTH];
   logic [LEN_W-1:0]  remaining_ff [DEPTH];
   logic [LEN_W-1:0]  total_ff     [DEPTH];
   logic [MASK_W-1:0] pend_ff;
   logic [MASK_W-1:0] pend_in;

   always_comb begin
      active_in = active_ff;
      pend_in   = pend_ff;
      if (wr.en) begin
         pend_in = wr.pend_next;
         if (wr.clear_all) begin
            active_in = '0;
         end else if (wr.act_wr) begin
            active_in[idx] = wr.act_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         pend_ff   <= '0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.data_wr) begin
         address_ff[idx]   <= wr.address;
         remaining_ff[idx] <= wr.remaining;
      end
      if (wr.en && wr.total_wr) begin
         total_ff[idx] <= wr.total;
      end
   end

   assign rd.active    = active_ff[idx];
   assign rd.address   = address_ff[idx];
   assign rd.remaining = remaining_ff[idx];
   assign rd.total     = total_ff[idx];
   assign pend         = pend_ff;

endmodule

FILE: design/usbet_step.sv
// Command decode and per-packet arithmetic for one request against its slot entry.
module usbet_step
   import usbet_pkg::*;
#(
   parameter int NUM_SLOTS     = USBET_NUM_SLOTS,
   parameter int HS_MAX_PACKET = USBET_HS_MAX_PACKET
) (
   input  logic               go,
   input  kind_type           kind,
   input  cmd_type            cmd,
   input  logic [SLOT_W-1:0]  slot,
   input  logic [LEN_W-1:0]   length,
   input  logic [ADDR_W-1:0]  buffer_address,
   input  logic [BYTES_W-1:0] bytes_waiting,
   input  logic               buffer_full,
   input  tbl_rd_type         rd,
   input  logic [MASK_W-1:0]  pend,
   output tbl_wr_type         wr,
   output rsp_type            res
);

   logic               slot_ok;
   logic               is_in;
   logic [LIM_W-1:0]   lim;
   logic [MASK_W-1:0]  bit_mask;
   logic [LIM_W-1:0]   first_bytes;
   logic [LIM_W-1:0]   sent;
   logic [LEN_W-1:0]   in_rem;
   logic [ADDR_W-1:0]  in_addr;
   logic [LIM_W-1:0]   next_bytes;
   logic [BYTES_W-1:0] avail;
   logic               out_block;
   logic [BYTES_W-1:0] take;
   logic [LEN_W-1:0]   out_rem;
   logic               out_done;

   always_comb begin
      slot_ok  = (LIM_W'(slot) < LIM_W'(NUM_SLOTS));
      is_in    = slot[0];
      bit_mask = MASK_W'(1) << slot;
      if (kind == KIND_HIGH_SPEED) begin
         lim = LIM_W'(HS_MAX_PACKET);
      end else if (slot < SLOT_W'(FS_SMALL_SLOTS)) begin
         lim = LIM_W'(FS_SMALL_PACKET);
      end else begin
         lim = LIM_W'(FS_LARGE_PACKET);
      end

      first_bytes = (length < LEN_W'(lim)) ? length[LIM_W-1:0] : lim;

      sent       = (rd.remaining < LEN_W'(lim)) ? rd.remaining[LIM_W-1:0] : lim;
      in_rem     = rd.remaining - LEN_W'(sent);
      in_addr    = rd.address + ADDR_W'(sent);
      next_bytes = (in_rem < LEN_W'(lim)) ? in_rem[LIM_W-1:0] : lim;

      if (kind == KIND_HIGH_SPEED) begin
         avail     = bytes_waiting;
         out_block = (rd.remaining != '0) && (bytes_waiting == '0);
      end else begin
         avail     = buffer_full ? {2'b00, bytes_waiting[7:0]} : '0;
         out_block = !buffer_full && (rd.remaining != '0);
      end
      take     = (rd.remaining < LEN_W'(avail)) ? rd.remaining[BYTES_W-1:0] : avail;
      out_rem  = rd.remaining - LEN_W'(take);
      out_done = (LIM_W'(avail) < lim) || (out_rem == '0);

      wr           = '0;
      wr.en        = go;
      wr.pend_next = pend;
      res          = '0;
      res.action   = ACT_NONE;

      unique case (cmd)
         CMD_BUS_RESET: begin
            wr.clear_all = 1'b1;
            wr.pend_next = '0;
            res.ok       = 1'b1;
         end
         CMD_SUBMIT: begin
            if (slot_ok && !rd.active) begin
               wr.act_wr    = 1'b1;
               wr.act_val   = 1'b1;
               wr.data_wr   = 1'b1;
               wr.total_wr  = 1'b1;
               wr.address   = buffer_address;
               wr.remaining = length;
               wr.total     = length;
               res.ok       = 1'b1;
               if (kind == KIND_HIGH_SPEED && length == '0) begin
                  res.action = ACT_STATUS;
               end else if (is_in) begin
                  res.action       = ACT_SEND;
                  res.move_bytes   = first_bytes[BYTES_W-1:0];
                  res.move_address = buffer_address;
               end
            end
         end
         CMD_EVENT: begin
            if (slot_ok) begin
               if (!rd.active) begin
                  wr.pend_next = pend | bit_mask;
               end else if (is_in) begin
                  wr.data_wr   = 1'b1;
                  wr.address   = in_addr;
                  wr.remaining = in_rem;
                  wr.pend_next = pend & ~bit_mask;
                  res.ok       = 1'b1;
                  if (in_rem == '0) begin
                     wr.act_wr           = 1'b1;
                     wr.act_val          = 1'b0;
                     res.complete        = 1'b1;
                     res.complete_length = rd.total;
                  end else begin
                     res.action       = ACT_SEND;
                     res.move_bytes   = next_bytes[BYTES_W-1:0];
                     res.move_address = in_addr;
                  end
               end else if (out_block) begin
                  wr.pend_next = pend | bit_mask;
               end else begin
                  wr.data_wr       = 1'b1;
                  wr.address       = rd.address + ADDR_W'(take);
                  wr.remaining     = out_rem;
                  wr.pend_next     = pend & ~bit_mask;
                  res.ok           = 1'b1;
                  res.action       = ACT_READ;
                  res.move_bytes   = take;
                  res.move_address = rd.address;
                  if (out_done) begin
                     wr.act_wr           = 1'b1;
                     wr.act_val          = 1'b0;
                     res.complete        = 1'b1;
                     res.complete_length = rd.total;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      res.pending_mask = wr.pend_next;
   end

endmodule

FILE: design/usb_endpoint_transfer_tracker.sv
// Top level of the USB endpoint transfer tracker: request register, slot table, response register.
//
//   channel  | ports                         | direction
//   ---------+-------------------------------+----------
//   request  | req_valid, req_stall, req_*   | in
//   response | rsp_valid, rsp_stall, rsp_*   | out
//   config   | csr_wr_en, csr_wr_data        | in
//
// One request per cycle while req_stall is low; the response comes from the response register.
// The slot table is read and updated in the cycle between the request and response
// registers, so back-to-back requests on one slot see each other's updates.
// Synchronous reset disarms all slots, clears pending bits and the controller kind.
// A stalled response holds the pipeline; req_stall rises only while both stages are full.
module usb_endpoint_transfer_tracker
   import usbet_pkg::*;
#(
   parameter int NUM_SLOTS     = USBET_NUM_SLOTS,
   parameter int HS_MAX_PACKET = USBET_HS_MAX_PACKET
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_wr_en,
   input  logic               csr_wr_data,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [LEN_W-1:0]   req_length,
   input  logic [ADDR_W-1:0]  req_buffer_address,
   input  logic [BYTES_W-1:0] req_bytes_waiting,
   input  logic               req_buffer_full,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [1:0]         rsp_action,
   output logic [BYTES_W-1:0] rsp_move_bytes,
   output logic [ADDR_W-1:0]  rsp_move_address,
   output logic               rsp_complete,
   output logic [LEN_W-1:0]   rsp_complete_length,
   output logic [MASK_W-1:0]  rsp_pending_mask
);

   localparam int DEPTH = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   kind_type           kind_ff;
   logic               s1_vld_ff;
   cmd_type            cmd_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [LEN_W-1:0]   length_ff;
   logic [ADDR_W-1:0]  address_ff;
   logic [BYTES_W-1:0] waiting_ff;
   logic               full_ff;
   logic               rsp_vld_ff;
   rsp_type            rsp_ff;

   logic               advance;
   logic               fire;
   logic               accept;
   tbl_rd_type         tbl_rd;
   tbl_wr_type         tbl_wr;
   logic [MASK_W-1:0]  pend;
   rsp_type            rsp_in;

   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign fire      = s1_vld_ff && advance;
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_HIGH_SPEED;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            kind_ff <= kind_type'(csr_wr_data);
         end
         if (!req_stall) begin
            s1_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= cmd_type'(req_cmd);
         slot_ff    <= req_slot;
         length_ff  <= req_length;
         address_ff <= req_buffer_address;
         waiting_ff <= req_bytes_waiting;
         full_ff    <= req_buffer_full;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   usbet_slot_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .idx   (slot_ff[IDX_W-1:0]),
      .wr    (tbl_wr),
      .rd    (tbl_rd),
      .pend  (pend)
   );

   usbet_step #(
      .NUM_SLOTS     (NUM_SLOTS),
      .HS_MAX_PACKET (HS_MAX_PACKET)
   ) u_step (
      .go             (fire),
      .kind           (kind_ff),
      .cmd            (cmd_ff),
      .slot           (slot_ff),
      .length         (length_ff),
      .buffer_address (address_ff),
      .bytes_waiting  (waiting_ff),
      .buffer_full    (full_ff),
      .rd             (tbl_rd),
      .pend           (pend),
      .wr             (tbl_wr),
      .res            (rsp_in)
   );

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_ok              = rsp_ff.ok;
   assign rsp_action          = rsp_ff.action;
   assign rsp_move_bytes      = rsp_ff.move_bytes;
   assign rsp_move_address    = rsp_ff.move_address;
   assign rsp_complete        = rsp_ff.complete;
   assign rsp_complete_length = rsp_ff.complete_length;
   assign rsp_pending_mask    = rsp_ff.pending_mask;

endmodule
